### hdl/fwdf_pkg.sv
// ----------------------------------------------------------------------------
// fwdf_pkg
// Shared types, character codes and reciprocal constants for the fixed-width
// decimal formatter.
// ----------------------------------------------------------------------------
package fwdf_pkg;

   localparam int CmdW     = 4;
   localparam int ValueW   = 24;
   localparam int CharW    = 8;
   localparam int MaxChars = 7;
   localparam int CntW     = $clog2(MaxChars + 1);

   localparam int MagW  = 24;   // magnitude of the most negative value fits unsigned
   localparam int Q4W   = 10;   // mag / 10000 <= 838
   localparam int R4W   = 14;   // mag % 10000
   localparam int Q4dW  = 7;    // (mag / 10000) / 10 <= 83
   localparam int TwoW  = 7;    // two-digit chunk, < 100
   localparam int DigW  = 4;

   // exact reciprocal multiply: q = (x * Recip) >> Shift over the full input range
   localparam logic [24:0] Recip10k      = 25'd27487791;
   localparam int          Recip10kShift = 38;
   localparam logic [10:0] Recip10Q4     = 11'd1639;
   localparam int          Recip10Q4Shift = 14;
   localparam logic [14:0] Recip100      = 15'd20972;
   localparam int          Recip100Shift = 21;
   localparam logic [7:0]  Recip10       = 8'd205;
   localparam int          Recip10Shift  = 11;

   localparam logic [13:0] TenThousand = 14'd10000;
   localparam logic [6:0]  Hundred     = 7'd100;

   typedef logic [CharW-1:0] char_type;
   typedef logic [DigW-1:0]  digit_type;

   localparam char_type CharZero  = 8'h30;
   localparam char_type CharNine  = 8'h39;
   localparam char_type CharDot   = 8'h2E;
   localparam char_type CharMinus = 8'h2D;
   localparam char_type CharPlus  = 8'h2B;
   localparam char_type CharSpace = 8'h20;

   typedef enum logic [CmdW-1:0] {
      FmtTwoDigit    = 4'd0,
      FmtSign31      = 4'd1,
      FmtMag31       = 4'd2,
      FmtSignDigit32 = 4'd3,
      FmtPad22       = 4'd4,
      FmtSignDigit13 = 4'd5,
      FmtMag12       = 4'd6,
      FmtSpace13     = 4'd7,
      FmtBlank22     = 4'd8,
      FmtSignInt31   = 4'd9,
      FmtRight3      = 4'd10,
      FmtLeft3       = 4'd11,
      FmtRight4      = 4'd12,
      FmtRight5      = 4'd13,
      FmtSign41      = 4'd14,
      FmtSign32      = 4'd15
   } fmt_type;

   // digit record handed from the conversion pipeline to the output side
   typedef struct packed {
      fmt_type        fmt;
      logic           neg;
      logic [4:1]     ge;    // ge[k]: magnitude >= 10^k
      digit_type      d4;
      digit_type      d3;
      digit_type      d2;
      logic [TwoW-1:0] r2;   // low two digits, still binary
   } dig_type;

   // split a value below 100 into tens and units
   function automatic logic [2*DigW-1:0] split10(input logic [TwoW-1:0] x);
      logic [14:0]     prod;
      digit_type       tens;
      logic [TwoW:0]   tens_x10;
      digit_type       units;
      prod     = x * Recip10;
      tens     = prod[Recip10Shift +: DigW];
      tens_x10 = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0};
      units    = x[DigW-1:0] - tens_x10[DigW-1:0];
      return {tens, units};
   endfunction

endpackage

### hdl/fwdf_channels.sv
// ----------------------------------------------------------------------------
// fwdf channels
// Valid/ready channel interfaces: request (format select and value) and
// response (one character per beat).
// ----------------------------------------------------------------------------
interface fwdf_req_if import fwdf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CmdW-1:0]          cmd;
   logic signed [ValueW-1:0] value;

   modport source (output valid, cmd, value, input ready);
   modport sink   (input valid, cmd, value, output ready);
endinterface

interface fwdf_rsp_if import fwdf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CharW-1:0] char_code;
   logic             last;

   modport source (output valid, char_code, last, input ready);
   modport sink   (input valid, char_code, last, output ready);
endinterface

### hdl/fwdf_digits.sv
// ----------------------------------------------------------------------------
// fwdf_digits
// Six-stage pipeline: input register, magnitude, then decimal digits by
// reciprocal multiplication.
// ----------------------------------------------------------------------------
module fwdf_digits import fwdf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   fwdf_req_if.sink    req_bus,
   output logic        dig_valid,
   input  logic        dig_ready,
   output dig_type     dig
);

   localparam int NumStg = 6;

   typedef struct packed {
      fmt_type             fmt;
      logic [ValueW-1:0]   value;
   } s0_type;

   typedef struct packed {
      fmt_type           fmt;
      logic              neg;
      logic [MagW-1:0]   mag;
   } s1_type;

   typedef struct packed {
      fmt_type          fmt;
      logic             neg;
      logic [3:1]       ge;
      logic [Q4W-1:0]   q4;
      logic [R4W-1:0]   mlo;
   } s2_type;

   typedef struct packed {
      fmt_type           fmt;
      logic              neg;
      logic [4:1]        ge;
      digit_type         q4lo;
      logic [Q4dW-1:0]   q4d;
      logic [R4W-1:0]    r4;
   } s3_type;

   typedef struct packed {
      fmt_type           fmt;
      logic              neg;
      logic [4:1]        ge;
      digit_type         d4;
      logic [TwoW-1:0]   q2;
      logic [TwoW-1:0]   r4lo;
   } s4_type;

   logic [NumStg-1:0] vld_ff, vld_in, adv;

   s0_type  s0_ff;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   s4_type  s4_ff, s4_in;
   dig_type s5_ff, s5_in;

   logic [48:0]      prod4;
   logic [23:0]      p4;
   logic [20:0]      pq;
   logic [Q4W-1:0]   q4d_x10;
   logic [28:0]      p2;
   logic [13:0]      hp;
   logic             neg0;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      adv[NumStg-1] = ~vld_ff[NumStg-1] | dig_ready;
      for (int k = NumStg - 2; k >= 0; k--) begin
         adv[k] = ~vld_ff[k] | adv[k+1];
      end
      vld_in[0] = adv[0] ? req_bus.valid : vld_ff[0];
      for (int k = 1; k < NumStg; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign req_bus.ready = adv[0];
   assign dig_valid     = vld_ff[NumStg-1];
   assign dig           = s5_ff;

   // stage 1: sign and magnitude; the two-digit format reads the low byte unsigned
   always_comb begin
      neg0      = s0_ff.value[ValueW-1];
      s1_in.fmt = s0_ff.fmt;
      s1_in.neg = neg0;
      if (s0_ff.fmt == FmtTwoDigit) begin
         s1_in.mag = {{(MagW-8){1'b0}}, s0_ff.value[7:0]};
      end else if (neg0) begin
         s1_in.mag = ~s0_ff.value + 1'b1;
      end else begin
         s1_in.mag = s0_ff.value;
      end
   end

   // stage 2: ten-thousands quotient, range flags
   always_comb begin
      prod4     = s1_ff.mag * Recip10k;
      s2_in.fmt = s1_ff.fmt;
      s2_in.neg = s1_ff.neg;
      s2_in.ge  = {s1_ff.mag >= MagW'(1000), s1_ff.mag >= MagW'(100),
                   s1_ff.mag >= MagW'(10)};
      s2_in.q4  = prod4[Recip10kShift +: Q4W];
      s2_in.mlo = s1_ff.mag[R4W-1:0];
   end

   // stage 3: remainder below 10000, tens of the quotient
   always_comb begin
      p4         = s2_ff.q4 * TenThousand;
      pq         = s2_ff.q4 * Recip10Q4;
      s3_in.fmt  = s2_ff.fmt;
      s3_in.neg  = s2_ff.neg;
      s3_in.ge   = {s2_ff.q4 != '0, s2_ff.ge};
      s3_in.q4lo = s2_ff.q4[DigW-1:0];
      s3_in.q4d  = pq[Recip10Q4Shift +: Q4dW];
      s3_in.r4   = s2_ff.mlo - p4[R4W-1:0];
   end

   // stage 4: ten-thousands digit, hundreds quotient
   always_comb begin
      q4d_x10    = {s3_ff.q4d, 3'b000} + {2'b00, s3_ff.q4d, 1'b0};
      p2         = s3_ff.r4 * Recip100;
      s4_in.fmt  = s3_ff.fmt;
      s4_in.neg  = s3_ff.neg;
      s4_in.ge   = s3_ff.ge;
      s4_in.d4   = s3_ff.q4lo - q4d_x10[DigW-1:0];
      s4_in.q2   = p2[Recip100Shift +: TwoW];
      s4_in.r4lo = s3_ff.r4[TwoW-1:0];
   end

   // stage 5: thousands and hundreds digits, low two digits
   always_comb begin
      hp                   = s4_ff.q2 * Hundred;
      s5_in.fmt            = s4_ff.fmt;
      s5_in.neg            = s4_ff.neg;
      s5_in.ge             = s4_ff.ge;
      s5_in.d4             = s4_ff.d4;
      {s5_in.d3, s5_in.d2} = split10(s4_ff.q2);
      s5_in.r2             = s4_ff.r4lo - hp[TwoW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s0_ff.fmt   <= fmt_type'(req_bus.cmd);
         s0_ff.value <= req_bus.value;
      end
      if (adv[1]) s1_ff <= s1_in;
      if (adv[2]) s2_ff <= s2_in;
      if (adv[3]) s3_ff <= s3_in;
      if (adv[4]) s4_ff <= s4_in;
      if (adv[5]) s5_ff <= s5_in;
   end

   // reciprocal slips show up as digits out of range
   a_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      dig_valid |-> (dig.d4 <= 4'd9) && (dig.d3 <= 4'd9) && (dig.d2 <= 4'd9) &&
                    (dig.r2 <= 7'd99))
      else $error("fwdf_digits: non-decimal digit");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      dig_valid && !dig_ready |=> dig_valid && $stable(s5_ff))
      else $error("fwdf_digits: stalled digit record changed");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> vld_ff[0])
      else $error("fwdf_digits: accepted beat not captured");

endmodule

### hdl/fixed_width_decimal_formatter.sv
// ----------------------------------------------------------------------------
// fixed_width_decimal_formatter
// Formats a pre-scaled signed value as a fixed-width ASCII field, one
// character per response beat.
//
//   channel   dir  payload                         beat
//   req_bus   in   cmd[3:0] format, value[23:0]    one value to format
//   rsp_bus   out  char_code[7:0], last            one character, left first
//
// A value takes a six-register pipeline (input register, magnitude, four
// digit stages) and then enters the character buffer. A field of n
// characters (1 to 7, by format) drains at one beat per cycle while
// rsp_bus is ready, and the buffer takes the next value as the last
// character of the previous field goes out. The pipeline keeps taking
// values while the buffer drains, and back-pressure on rsp_bus stalls it
// stage by stage. Synchronous reset empties pipeline and buffer.
// ----------------------------------------------------------------------------
module fixed_width_decimal_formatter import fwdf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   fwdf_req_if.sink    req_bus,
   fwdf_rsp_if.source  rsp_bus
);

   logic      dig_valid;
   logic      dig_ready;
   dig_type   dig;

   digit_type d1, d0;
   char_type  c4, c3, c2, c1, c0, sgn;
   char_type  fmt_chr [MaxChars];
   logic [CntW-1:0] fmt_len;

   char_type  chr_ff [MaxChars];
   char_type  chr_in [MaxChars];
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic      beat;
   logic      load;

   fwdf_digits u_digits (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .dig_valid (dig_valid),
      .dig_ready (dig_ready),
      .dig       (dig)
   );

   always_comb begin
      {d1, d0} = split10(dig.r2);
      c4  = CharZero + {4'b0000, dig.d4};
      c3  = CharZero + {4'b0000, dig.d3};
      c2  = CharZero + {4'b0000, dig.d2};
      c1  = CharZero + {4'b0000, d1};
      c0  = CharZero + {4'b0000, d0};
      sgn = dig.neg ? CharMinus : CharPlus;
      for (int i = 0; i < MaxChars; i++) begin
         fmt_chr[i] = CharSpace;
      end
      fmt_len = '0;
      unique case (dig.fmt)
         FmtTwoDigit: begin
            fmt_chr[0] = c1; fmt_chr[1] = c0;
            fmt_len = CntW'(2);
         end
         FmtSign31, FmtSignInt31: begin
            fmt_chr[0] = sgn; fmt_chr[1] = c3; fmt_chr[2] = c2;
            fmt_chr[3] = c1; fmt_chr[4] = CharDot; fmt_chr[5] = c0;
            fmt_len = CntW'(6);
         end
         FmtMag31: begin
            fmt_chr[0] = c3; fmt_chr[1] = c2; fmt_chr[2] = c1;
            fmt_chr[3] = CharDot; fmt_chr[4] = c0;
            fmt_len = CntW'(5);
         end
         FmtSignDigit32: begin
            fmt_chr[0] = dig.neg ? CharMinus : c4;
            fmt_chr[1] = c3; fmt_chr[2] = c2; fmt_chr[3] = CharDot;
            fmt_chr[4] = c1; fmt_chr[5] = c0;
            fmt_len = CntW'(6);
         end
         FmtPad22: begin
            fmt_chr[0] = dig.ge[4] ? c4 : CharSpace;
            fmt_chr[1] = dig.ge[3] ? c3 : CharSpace;
            fmt_chr[2] = dig.ge[2] ? c2 : CharZero;
            fmt_chr[3] = CharDot; fmt_chr[4] = c1; fmt_chr[5] = c0;
            fmt_len = CntW'(6);
         end
         FmtSignDigit13: begin
            fmt_chr[0] = dig.neg ? CharMinus : c3;
            fmt_chr[1] = CharDot; fmt_chr[2] = c2; fmt_chr[3] = c1;
            fmt_chr[4] = c0;
            fmt_len = CntW'(5);
         end
         FmtMag12: begin
            fmt_chr[0] = c2; fmt_chr[1] = CharDot; fmt_chr[2] = c1;
            fmt_chr[3] = c0;
            fmt_len = CntW'(4);
         end
         FmtSpace13: begin
            fmt_chr[0] = dig.neg ? CharMinus : CharSpace;
            fmt_chr[1] = c3; fmt_chr[2] = CharDot; fmt_chr[3] = c2;
            fmt_chr[4] = c1; fmt_chr[5] = c0;
            fmt_len = CntW'(6);
         end
         FmtBlank22: begin
            // leading zeros blanked, trailing zeros of the fraction blanked
            if (dig.neg) begin
               fmt_chr[0] = CharMinus;
               fmt_chr[1] = (dig.d3 != '0) ? c3 : CharSpace;
            end else if (dig.d4 != '0) begin
               fmt_chr[0] = c4;
               fmt_chr[1] = c3;
            end else begin
               fmt_chr[0] = CharSpace;
               fmt_chr[1] = (dig.d3 != '0) ? c3 : CharSpace;
            end
            fmt_chr[2] = c2;
            if (d0 != '0) begin
               fmt_chr[3] = CharDot; fmt_chr[4] = c1; fmt_chr[5] = c0;
            end else if (d1 != '0) begin
               fmt_chr[3] = CharDot; fmt_chr[4] = c1; fmt_chr[5] = CharSpace;
            end else begin
               fmt_chr[3] = CharSpace; fmt_chr[4] = CharSpace; fmt_chr[5] = CharSpace;
            end
            fmt_len = CntW'(6);
         end
         FmtRight3: begin
            // negative drops the hundreds digit
            fmt_chr[0] = dig.neg ? CharMinus : (dig.ge[2] ? c2 : CharSpace);
            fmt_chr[1] = dig.ge[1] ? c1 : CharSpace;
            fmt_chr[2] = c0;
            fmt_len = CntW'(3);
         end
         FmtLeft3: begin
            if (dig.ge[2]) begin
               fmt_chr[0] = c2; fmt_chr[1] = c1; fmt_chr[2] = c0;
               fmt_len = CntW'(3);
            end else if (dig.ge[1]) begin
               fmt_chr[0] = c1; fmt_chr[1] = c0;
               fmt_len = CntW'(2);
            end else begin
               fmt_chr[0] = c0;
               fmt_len = CntW'(1);
            end
         end
         FmtRight4: begin
            fmt_chr[0] = dig.ge[3] ? c3 : CharSpace;
            fmt_chr[1] = dig.ge[2] ? c2 : CharSpace;
            fmt_chr[2] = dig.ge[1] ? c1 : CharSpace;
            fmt_chr[3] = c0;
            fmt_len = CntW'(4);
         end
         FmtRight5: begin
            fmt_chr[0] = dig.ge[4] ? c4 : CharSpace;
            fmt_chr[1] = dig.ge[3] ? c3 : CharSpace;
            fmt_chr[2] = dig.ge[2] ? c2 : CharSpace;
            fmt_chr[3] = dig.ge[1] ? c1 : CharSpace;
            fmt_chr[4] = c0;
            fmt_len = CntW'(5);
         end
         FmtSign41: begin
            fmt_chr[0] = sgn; fmt_chr[1] = c4; fmt_chr[2] = c3;
            fmt_chr[3] = c2; fmt_chr[4] = c1; fmt_chr[5] = CharDot;
            fmt_chr[6] = c0;
            fmt_len = CntW'(7);
         end
         FmtSign32: begin
            fmt_chr[0] = sgn; fmt_chr[1] = c4; fmt_chr[2] = c3;
            fmt_chr[3] = c2; fmt_chr[4] = CharDot; fmt_chr[5] = c1;
            fmt_chr[6] = c0;
            fmt_len = CntW'(7);
         end
      endcase
   end

   // buffer reloads as the last character of the previous field goes out
   assign beat      = rsp_bus.valid & rsp_bus.ready;
   assign dig_ready = (cnt_ff == '0) | ((cnt_ff == CntW'(1)) & rsp_bus.ready);
   assign load      = dig_valid & dig_ready;

   always_comb begin
      chr_in = chr_ff;
      cnt_in = cnt_ff;
      if (load) begin
         chr_in = fmt_chr;
         cnt_in = fmt_len;
      end else if (beat) begin
         for (int i = 0; i < MaxChars - 1; i++) begin
            chr_in[i] = chr_ff[i+1];
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      chr_ff <= chr_in;
   end

   assign rsp_bus.valid     = cnt_ff != '0;
   assign rsp_bus.char_code = chr_ff[0];
   assign rsp_bus.last      = cnt_ff == CntW'(1);

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.char_code >= CharZero && rsp_bus.char_code <= CharNine) ||
                        rsp_bus.char_code == CharDot || rsp_bus.char_code == CharMinus ||
                        rsp_bus.char_code == CharPlus || rsp_bus.char_code == CharSpace)
      else $error("fixed_width_decimal_formatter: illegal character");

   a_field_no_gap: assert property (@(posedge clock) disable iff (reset)
      beat && !rsp_bus.last |=> rsp_bus.valid)
      else $error("fixed_width_decimal_formatter: gap inside a field");

   a_load_first: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_bus.valid && rsp_bus.char_code == $past(fmt_chr[0]))
      else $error("fixed_width_decimal_formatter: loaded field not presented");

   a_drain_idle: assert property (@(posedge clock) disable iff (reset)
      beat && rsp_bus.last && !dig_valid |=> !rsp_bus.valid)
      else $error("fixed_width_decimal_formatter: character invented after last");

endmodule

### tb/fwdf_field_checker.sv
// ----------------------------------------------------------------------------
// fwdf_field_checker
// Watches the request and response channels of the decimal formatter. Each
// accepted request is expanded into the characters of its text field; every
// response beat is compared, character and last flag, against the oldest
// character still owed.
// ----------------------------------------------------------------------------
module fwdf_field_checker import fwdf_pkg::*; (
   input  logic clock,
   input  logic reset,
   fwdf_req_if  req_bus,
   fwdf_rsp_if  rsp_bus,
   output int   error_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      char_type code;
      logic     last;
   } char_beat_type;

   char_beat_type expected_chars[$];
   int            fault_total = 0;

   function automatic char_type dec_digit(input int unsigned m, input int unsigned p);
      return CharZero + char_type'((m / p) % 10);
   endfunction

   function automatic char_type dec_digit_or_blank(input int unsigned m,
                                                   input int unsigned p);
      return (m >= p) ? dec_digit(m, p) : CharSpace;
   endfunction

   // expand one request into the characters of its field, left to right
   task automatic predict_field(input logic [CmdW-1:0] cmd,
                                input logic signed [ValueW-1:0] value);
      char_type      text[$];
      int            sval;
      logic          neg;
      int unsigned   mag;
      char_type      sgn;
      int unsigned   low_byte;
      int unsigned   thou;
      char_beat_type beat;
      sval     = value;
      neg      = sval < 0;
      mag      = neg ? -sval : sval;
      sgn      = neg ? CharMinus : CharPlus;
      low_byte = value[7:0];
      thou     = (mag / 1000) % 10;
      case (fmt_type'(cmd))
         FmtTwoDigit: begin
            text.push_back(dec_digit(low_byte, 10));
            text.push_back(dec_digit(low_byte, 1));
         end
         FmtSign31, FmtSignInt31: begin
            text.push_back(sgn);
            text.push_back(dec_digit(mag, 1000));
            text.push_back(dec_digit(mag, 100));
            text.push_back(dec_digit(mag, 10));
            text.push_back(CharDot);
            text.push_back(dec_digit(mag, 1));
         end
         FmtMag31: begin
            text.push_back(dec_digit(mag, 1000));
            text.push_back(dec_digit(mag, 100));
            text.push_back(dec_digit(mag, 10));
            text.push_back(CharDot);
            text.push_back(dec_digit(mag, 1));
         end
         FmtSignDigit32: begin
            text.push_back(neg ? CharMinus : dec_digit(mag, 10000));
            text.push_back(dec_digit(mag, 1000));
            text.push_back(dec_digit(mag, 100));
            text.push_back(CharDot);
            text.push_back(dec_digit(mag, 10));
            text.push_back(dec_digit(mag, 1));
         end
         FmtPad22: begin
            text.push_back(dec_digit_or_blank(mag, 10000));
            text.push_back(dec_digit_or_blank(mag, 1000));
            text.push_back((mag >= 100) ? dec_digit(mag, 100) : CharZero);
            text.push_back(CharDot);
            text.push_back(dec_digit(mag, 10));
            text.push_back(dec_digit(mag, 1));
         end
         FmtSignDigit13: begin
            text.push_back(neg ? CharMinus : dec_digit(mag, 1000));
            text.push_back(CharDot);
            text.push_back(dec_digit(mag, 100));
            text.push_back(dec_digit(mag, 10));
            text.push_back(dec_digit(mag, 1));
         end
         FmtMag12: begin
            text.push_back(dec_digit(mag, 100));
            text.push_back(CharDot);
            text.push_back(dec_digit(mag, 10));
            text.push_back(dec_digit(mag, 1));
         end
         FmtSpace13: begin
            text.push_back(neg ? CharMinus : CharSpace);
            text.push_back(dec_digit(mag, 1000));
            text.push_back(CharDot);
            text.push_back(dec_digit(mag, 100));
            text.push_back(dec_digit(mag, 10));
            text.push_back(dec_digit(mag, 1));
         end
         FmtBlank22: begin
            // leading thousands digit blanked when zero unless ten-thousands shown
            if (neg) begin
               text.push_back(CharMinus);
               text.push_back(thou != 0 ? dec_digit(mag, 1000) : CharSpace);
            end else if ((mag / 10000) % 10 != 0) begin
               text.push_back(dec_digit(mag, 10000));
               text.push_back(dec_digit(mag, 1000));
            end else begin
               text.push_back(CharSpace);
               text.push_back(thou != 0 ? dec_digit(mag, 1000) : CharSpace);
            end
            text.push_back(dec_digit(mag, 100));
            // trailing zeros of the fraction turn into blanks
            if (mag % 10 != 0) begin
               text.push_back(CharDot);
               text.push_back(dec_digit(mag, 10));
               text.push_back(dec_digit(mag, 1));
            end else if ((mag / 10) % 10 != 0) begin
               text.push_back(CharDot);
               text.push_back(dec_digit(mag, 10));
               text.push_back(CharSpace);
            end else begin
               text.push_back(CharSpace);
               text.push_back(CharSpace);
               text.push_back(CharSpace);
            end
         end
         FmtRight3: begin
            text.push_back(neg ? CharMinus : dec_digit_or_blank(mag, 100));
            text.push_back(dec_digit_or_blank(mag, 10));
            text.push_back(dec_digit(mag, 1));
         end
         FmtLeft3: begin
            if (mag >= 100) text.push_back(dec_digit(mag, 100));
            if (mag >= 10) text.push_back(dec_digit(mag, 10));
            text.push_back(dec_digit(mag, 1));
         end
         FmtRight4: begin
            text.push_back(dec_digit_or_blank(mag, 1000));
            text.push_back(dec_digit_or_blank(mag, 100));
            text.push_back(dec_digit_or_blank(mag, 10));
            text.push_back(dec_digit(mag, 1));
         end
         FmtRight5: begin
            text.push_back(dec_digit_or_blank(mag, 10000));
            text.push_back(dec_digit_or_blank(mag, 1000));
            text.push_back(dec_digit_or_blank(mag, 100));
            text.push_back(dec_digit_or_blank(mag, 10));
            text.push_back(dec_digit(mag, 1));
         end
         FmtSign41: begin
            text.push_back(sgn);
            text.push_back(dec_digit(mag, 10000));
            text.push_back(dec_digit(mag, 1000));
            text.push_back(dec_digit(mag, 100));
            text.push_back(dec_digit(mag, 10));
            text.push_back(CharDot);
            text.push_back(dec_digit(mag, 1));
         end
         default: begin
            text.push_back(sgn);
            text.push_back(dec_digit(mag, 10000));
            text.push_back(dec_digit(mag, 1000));
            text.push_back(dec_digit(mag, 100));
            text.push_back(CharDot);
            text.push_back(dec_digit(mag, 10));
            text.push_back(dec_digit(mag, 1));
         end
      endcase
      for (int k = 0; k < text.size(); k++) begin
         beat.code = text[k];
         beat.last = (k == text.size() - 1);
         expected_chars.push_back(beat);
      end
   endtask

   always @(posedge clock) begin
      char_beat_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            predict_field(req_bus.cmd, req_bus.value);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_chars.size() == 0) begin
               $error("char_code: expected no beat, actual %h", rsp_bus.char_code);
               fault_total++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_bus.char_code !== want.code) begin
                  $error("char_code: expected %h, actual %h", want.code, rsp_bus.char_code);
                  fault_total++;
               end
               if (rsp_bus.last !== want.last) begin
                  $error("last: expected %b, actual %b", want.last, rsp_bus.last);
                  fault_total++;
               end
            end
         end
      end
      error_count   <= fault_total;
      pending_count <= expected_chars.size();
   end

endmodule

### tb/fixed_width_decimal_formatter_test.sv
// ----------------------------------------------------------------------------
// fixed_width_decimal_formatter_test
// Drives directed and random format/value requests into the decimal
// formatter with random idle bursts on both channels; the field checker
// predicts every character and reports mismatches.
// ----------------------------------------------------------------------------
module fixed_width_decimal_formatter_test import fwdf_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomItems = 244;
   localparam int StallLimit  = 400;
   localparam int DrainCycles = 20;

   logic clock = 1'b0;
   logic reset;
   logic idle_on;
   int   error_count;
   int   pending_count;

   fwdf_req_if req_if ();
   fwdf_rsp_if rsp_if ();

   fixed_width_decimal_formatter dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   fwdf_field_checker field_check (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_if),
      .rsp_bus       (rsp_if),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // one request beat, with an optional idle burst in front of it
   task automatic send_value(input fmt_type fmt, input logic signed [ValueW-1:0] value);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd   <= fmt;
      req_if.value <= value;
      do @(posedge clock); while (!req_if.ready);
   endtask

   function automatic logic signed [ValueW-1:0] pick_value();
      logic signed [ValueW-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = ValueW'($urandom());
         3, 4, 5, 6: v = ValueW'($urandom_range(0, 99999));
         7: v = ValueW'($urandom_range(0, 999) * (($urandom_range(0, 1) != 0) ? 10 : 100));
         8: v = ValueW'($urandom_range(0, 120));
         default: begin
            case ($urandom_range(0, 3))
               0: v = {1'b1, {(ValueW-1){1'b0}}};
               1: v = {1'b0, {(ValueW-1){1'b1}}};
               2: v = '0;
               default: v = '1;
            endcase
         end
      endcase
      if ($urandom_range(0, 2) == 0) v = -v;
      return v;
   endfunction

   initial begin : rsp_backpressure
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin : watchdog
      int idle_run;
      idle_run = 0;
      while (idle_run < StallLimit) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_run = 0;
         else
            idle_run++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      reset        <= 1'b1;
      idle_on      <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.cmd   <= FmtTwoDigit;
      req_if.value <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: every format, field extremes, sign and padding corner cases
      send_value(FmtTwoDigit, 24'sd255);
      send_value(FmtTwoDigit, -24'sd1);
      send_value(FmtSign31, -24'sd1234);
      send_value(FmtMag31, {1'b1, {(ValueW-1){1'b0}}});
      send_value(FmtSignDigit32, -24'sd12345);
      send_value(FmtSignDigit32, 24'sd98765);
      send_value(FmtPad22, 24'sd5);
      send_value(FmtPad22, 24'sd123456);
      send_value(FmtSignDigit13, -24'sd1234);
      send_value(FmtSignDigit13, 24'sd5678);
      send_value(FmtMag12, -24'sd987);
      send_value(FmtSpace13, 24'sd1234);
      send_value(FmtSpace13, -24'sd1);
      send_value(FmtBlank22, -24'sd1200);
      send_value(FmtBlank22, 24'sd12000);
      send_value(FmtBlank22, 24'sd12340);
      send_value(FmtBlank22, 24'sd5);
      send_value(FmtSignInt31, {1'b0, {(ValueW-1){1'b1}}});
      send_value(FmtRight3, -24'sd5);
      send_value(FmtRight3, 24'sd7);
      send_value(FmtLeft3, 24'sd0);
      send_value(FmtLeft3, -24'sd12345);
      send_value(FmtRight4, 24'sd42);
      send_value(FmtRight5, {1'b0, {(ValueW-1){1'b1}}});
      send_value(FmtSign41, {1'b1, {(ValueW-1){1'b0}}});
      send_value(FmtSign32, 24'sd0);

      for (int i = 0; i < RandomItems; i++) begin
         // calm stretch in the first half, none at all near the end
         idle_on <= !((i >= 60 && i < 90) || i >= RandomItems - 40);
         if (i == RandomItems / 2) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         send_value(fmt_type'($urandom_range(0, 15)), pick_value());
      end
      req_if.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
